// ===== rtl/core/isvs_pkg.sv =====
// ----------------------------------------------------------------------------
// isvs_pkg
// Shared constants, codes and types of the iSLIP crossbar scheduler.
// ----------------------------------------------------------------------------
package isvs_pkg;

  // Switch geometry and queue sizing.
  localparam int NUM_PORTS   = 8;
  localparam int PORT_W      = 3;
  localparam int NUM_QUEUES  = NUM_PORTS * NUM_PORTS;
  localparam int QIDX_W      = 2 * PORT_W;
  localparam int QUEUE_DEPTH = 16;
  localparam int DEPTH_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int STORE_AW    = QIDX_W + DEPTH_W;
  localparam int META_W      = COUNT_W + 2 * DEPTH_W;
  localparam int TIME_W      = 32;
  localparam int ITER_W      = 4;
  localparam int MAX_ITERATIONS = 8;

  // Result kinds.
  localparam logic [1:0] KIND_STORED   = 2'd0;
  localparam logic [1:0] KIND_DROPPED  = 2'd1;
  localparam logic [1:0] KIND_MATCH    = 2'd2;
  localparam logic [1:0] KIND_NO_MATCH = 2'd3;

  // Operation codes.
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_SLOT    = 1'b1;

  // Result of one round-robin search.
  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] idx;
  } pick_t;

  // Per-queue bookkeeping held in the queue state memory.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DEPTH_W-1:0] head;
    logic [DEPTH_W-1:0] tail;
  } meta_t;

endpackage

// ===== rtl/core/isvs_in_if.sv =====
// ----------------------------------------------------------------------------
// isvs_in_if
// Request channel: packet arrivals and slot commands.
// ----------------------------------------------------------------------------
interface isvs_in_if import isvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] arr_stamp;
  logic [PORT_W-1:0] in_port;
  logic [PORT_W-1:0] out_port;

  modport source (output valid, operation, arr_stamp, in_port, out_port, input ready);
  modport sink   (input valid, operation, arr_stamp, in_port, out_port, output ready);
endinterface

// ===== rtl/core/isvs_out_if.sv =====
// ----------------------------------------------------------------------------
// isvs_out_if
// Result channel: arrival outcomes and matches.
// ----------------------------------------------------------------------------
interface isvs_out_if import isvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [TIME_W-1:0] packet_time;
  logic [PORT_W-1:0] match_input;
  logic [PORT_W-1:0] match_output;
  logic [TIME_W-1:0] slot_time;
  logic              last;

  modport source (output valid, kind, packet_time, match_input, match_output, slot_time,
                  last, input ready);
  modport sink   (input valid, kind, packet_time, match_input, match_output, slot_time,
                  last, output ready);
endinterface

// ===== rtl/core/isvs_ram.sv =====
// ----------------------------------------------------------------------------
// isvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/isvs_rr_pick.sv =====
// ----------------------------------------------------------------------------
// isvs_rr_pick
// Round-robin search: first set request at or after the start pointer.
// ----------------------------------------------------------------------------
module isvs_rr_pick import isvs_pkg::*; (
  input  logic [NUM_PORTS-1:0] req_i,
  input  logic [PORT_W-1:0]    ptr_i,
  output pick_t                pick_o
);

  // Scan from the farthest position back, so the nearest hit wins.
  always_comb begin
    logic [PORT_W-1:0] c;
    pick_o = '0;
    for (int s = NUM_PORTS - 1; s >= 0; s--) begin
      c = ptr_i + PORT_W'(s);
      if (req_i[c]) begin
        pick_o.found = 1'b1;
        pick_o.idx   = c;
      end
    end
  end

endmodule

// ===== rtl/core/islip_voq_switch_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// islip_voq_switch_scheduler_top
// iSLIP crossbar scheduler over per-pair virtual output queues, run by a
// small sequencer around one shared round-robin search unit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_i     | in  | valid/ready   | operation, arr_stamp, in_port, out_port
//  out_o    | out | valid/ready   | kind, packet_time, match_input, match_output,
//           |     |               | slot_time, last
//  cfg      | in  | cfg_we_i      | cfg_data_i (iterations)
//
// An arrival beat reads the queue state, then updates it and issues the result.
// A slot beat runs its rounds, each a grant pass over the outputs and an accept
// pass over the inputs: the shared search unit serves one output or one input a
// cycle, and each match adds a queue state read and a timestamp read.
// Reset clears all pointers, counters and the per-queue valid bits; no clearing
// pass is run. A stalled result register stalls the sequencer, and a new beat is
// taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
module islip_voq_switch_scheduler_top import isvs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  isvs_in_if.sink           in_i,
  isvs_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [ITER_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ARR   = 3'd1;
  localparam logic [2:0] ST_GRANT = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_META  = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_END   = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [ITER_W-1:0]       iter_cfg_q, iter_cfg_d;
  logic [ITER_W-1:0]       rounds_q, rounds_d;
  logic [ITER_W-1:0]       round_q, round_d;
  logic [PORT_W-1:0]       port_q, port_d;
  logic [TIME_W-1:0]       slot_q, slot_d;
  logic [NUM_PORTS-1:0]    in_link_q, in_link_d;
  logic [NUM_PORTS-1:0]    out_link_q, out_link_d;
  logic [NUM_PORTS-1:0]    gnt_vld_q, gnt_vld_d;
  logic [PORT_W-1:0]       gnt_idx_q [NUM_PORTS];
  logic [PORT_W-1:0]       gnt_idx_d [NUM_PORTS];
  logic [PORT_W-1:0]       gp_q [NUM_PORTS];
  logic [PORT_W-1:0]       gp_d [NUM_PORTS];
  logic [PORT_W-1:0]       ap_q [NUM_PORTS];
  logic [PORT_W-1:0]       ap_d [NUM_PORTS];
  logic [NUM_QUEUES-1:0]   ne_q, ne_d;
  logic [NUM_QUEUES-1:0]   mvld_q, mvld_d;
  logic                    mrd_vld_q, mrd_vld_d;
  logic [QIDX_W-1:0]       qsel_q, qsel_d;
  logic [TIME_W-1:0]       atime_q, atime_d;
  logic                    pend_q, pend_d;
  logic [TIME_W-1:0]       pend_time_q, pend_time_d;
  logic [PORT_W-1:0]       pend_in_q, pend_in_d;
  logic [PORT_W-1:0]       pend_out_q, pend_out_d;
  logic                    ovld_q, ovld_d;
  logic [1:0]              okind_q, okind_d;
  logic [TIME_W-1:0]       optime_q, optime_d;
  logic [PORT_W-1:0]       oin_q, oin_d;
  logic [PORT_W-1:0]       oout_q, oout_d;
  logic [TIME_W-1:0]       oslot_q, oslot_d;
  logic                    olast_q, olast_d;

  logic                    out_free;
  logic [NUM_PORTS-1:0]    pick_req;
  logic [PORT_W-1:0]       pick_ptr;
  pick_t                   pick;
  logic                    meta_we, meta_re;
  logic [QIDX_W-1:0]       meta_waddr, meta_raddr;
  meta_t                   meta_wdata, meta_rdata, meta_cur;
  logic                    store_we, store_re;
  logic [STORE_AW-1:0]     store_waddr, store_raddr;
  logic [TIME_W-1:0]       store_rdata;

  // Queue state memory and timestamp store.
  isvs_ram #(.WIDTH(META_W), .DEPTH(NUM_QUEUES)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(meta_waddr), .wdata_i(meta_wdata),
    .re_i(meta_re), .raddr_i(meta_raddr), .rdata_o(meta_rdata)
  );

  isvs_ram #(.WIDTH(TIME_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i, .we_i(store_we), .waddr_i(store_waddr), .wdata_i(atime_q),
    .re_i(store_re), .raddr_i(store_raddr), .rdata_o(store_rdata)
  );

  // Shared round-robin search, used for grants and for accepts.
  isvs_rr_pick u_pick (.req_i(pick_req), .ptr_i(pick_ptr), .pick_o(pick));

  always_comb begin
    for (int c = 0; c < NUM_PORTS; c++) begin
      if (state_q == ST_GRANT) begin
        pick_req[c] = ne_q[c * NUM_PORTS + int'(port_q)] & ~in_link_q[c];
      end else begin
        pick_req[c] = gnt_vld_q[c] && (gnt_idx_q[c] == port_q);
      end
    end
    pick_ptr = (state_q == ST_GRANT) ? gp_q[port_q] : ap_q[port_q];
  end

  assign out_free = ~ovld_q | out_o.ready;
  assign meta_cur = mrd_vld_q ? meta_rdata : '0;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = ovld_q;
  assign out_o.kind         = okind_q;
  assign out_o.packet_time  = optime_q;
  assign out_o.match_input  = oin_q;
  assign out_o.match_output = oout_q;
  assign out_o.slot_time    = oslot_q;
  assign out_o.last         = olast_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    iter_cfg_d  = cfg_we_i ? cfg_data_i : iter_cfg_q;
    rounds_d    = rounds_q;
    round_d     = round_q;
    port_d      = port_q;
    slot_d      = slot_q;
    in_link_d   = in_link_q;
    out_link_d  = out_link_q;
    gnt_vld_d   = gnt_vld_q;
    gnt_idx_d   = gnt_idx_q;
    gp_d        = gp_q;
    ap_d        = ap_q;
    ne_d        = ne_q;
    mvld_d      = mvld_q;
    mrd_vld_d   = mrd_vld_q;
    qsel_d      = qsel_q;
    atime_d     = atime_q;
    pend_d      = pend_q;
    pend_time_d = pend_time_q;
    pend_in_d   = pend_in_q;
    pend_out_d  = pend_out_q;
    ovld_d      = ovld_q & ~out_o.ready;
    okind_d     = okind_q;
    optime_d    = optime_q;
    oin_d       = oin_q;
    oout_d      = oout_q;
    oslot_d     = oslot_q;
    olast_d     = olast_q;
    meta_we     = 1'b0;
    meta_re     = 1'b0;
    meta_waddr  = qsel_q;
    meta_raddr  = qsel_q;
    meta_wdata  = meta_cur;
    store_we    = 1'b0;
    store_re    = 1'b0;
    store_waddr = {qsel_q, meta_cur.tail};
    store_raddr = {qsel_q, meta_cur.head};

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.operation == OP_ARRIVAL) begin
            qsel_d     = {in_i.in_port, in_i.out_port};
            atime_d    = in_i.arr_stamp;
            meta_re    = 1'b1;
            meta_raddr = {in_i.in_port, in_i.out_port};
            mrd_vld_d  = mvld_q[{in_i.in_port, in_i.out_port}];
            state_d    = ST_ARR;
          end else begin
            rounds_d   = (iter_cfg_q > ITER_W'(MAX_ITERATIONS)) ?
                         ITER_W'(MAX_ITERATIONS) : iter_cfg_q;
            round_d    = '0;
            port_d     = '0;
            in_link_d  = '0;
            out_link_d = '0;
            pend_d     = 1'b0;
            state_d    = (iter_cfg_q == '0) ? ST_END : ST_GRANT;
          end
        end
      end

      ST_ARR: begin
        if (out_free) begin
          ovld_d   = 1'b1;
          optime_d = atime_q;
          oin_d    = qsel_q[QIDX_W-1:PORT_W];
          oout_d   = qsel_q[PORT_W-1:0];
          oslot_d  = slot_q;
          olast_d  = 1'b1;
          if (meta_cur.count == COUNT_W'(QUEUE_DEPTH)) begin
            okind_d = KIND_DROPPED;
          end else begin
            okind_d          = KIND_STORED;
            store_we         = 1'b1;
            meta_we          = 1'b1;
            meta_wdata.count = meta_cur.count + 1'b1;
            meta_wdata.tail  = meta_cur.tail + 1'b1;
            ne_d[qsel_q]     = 1'b1;
            mvld_d[qsel_q]   = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      ST_GRANT: begin
        if (out_link_q[port_q] || !pick.found) begin
          gnt_vld_d[port_q] = 1'b0;
        end else begin
          gnt_vld_d[port_q] = 1'b1;
          gnt_idx_d[port_q] = pick.idx;
          gp_d[port_q]      = pick.idx;
        end
        port_d = port_q + 1'b1;
        if (port_q == PORT_W'(NUM_PORTS - 1)) begin
          state_d = ST_ACC;
        end
      end

      ST_ACC: begin
        if (!in_link_q[port_q] && pick.found) begin
          in_link_d[port_q]   = 1'b1;
          out_link_d[pick.idx] = 1'b1;
          ap_d[port_q]        = pick.idx + 1'b1;
          gp_d[pick.idx]      = port_q + 1'b1;
          qsel_d              = {port_q, pick.idx};
          meta_re             = 1'b1;
          meta_raddr          = {port_q, pick.idx};
          mrd_vld_d           = mvld_q[{port_q, pick.idx}];
          state_d             = ST_META;
        end else begin
          port_d = port_q + 1'b1;
          if (port_q == PORT_W'(NUM_PORTS - 1)) begin
            round_d = round_q + 1'b1;
            state_d = (round_q + 1'b1 == rounds_q) ? ST_END : ST_GRANT;
          end
        end
      end

      ST_META: begin
        store_re         = 1'b1;
        meta_we          = 1'b1;
        meta_wdata.count = meta_cur.count - 1'b1;
        meta_wdata.head  = meta_cur.head + 1'b1;
        if (meta_cur.count == COUNT_W'(1)) begin
          ne_d[qsel_q] = 1'b0;
        end
        state_d = ST_DATA;
      end

      ST_DATA: begin
        // The held match goes out once a newer one proves it is not the last.
        if (!pend_q || out_free) begin
          if (pend_q) begin
            ovld_d   = 1'b1;
            okind_d  = KIND_MATCH;
            optime_d = pend_time_q;
            oin_d    = pend_in_q;
            oout_d   = pend_out_q;
            oslot_d  = slot_q;
            olast_d  = 1'b0;
          end
          pend_d      = 1'b1;
          pend_time_d = store_rdata;
          pend_in_d   = qsel_q[QIDX_W-1:PORT_W];
          pend_out_d  = qsel_q[PORT_W-1:0];
          port_d      = port_q + 1'b1;
          if (port_q == PORT_W'(NUM_PORTS - 1)) begin
            round_d = round_q + 1'b1;
            state_d = (round_q + 1'b1 == rounds_q) ? ST_END : ST_GRANT;
          end else begin
            state_d = ST_ACC;
          end
        end
      end

      ST_END: begin
        if (out_free) begin
          ovld_d   = 1'b1;
          oslot_d  = slot_q;
          olast_d  = 1'b1;
          okind_d  = pend_q ? KIND_MATCH : KIND_NO_MATCH;
          optime_d = pend_q ? pend_time_q : '0;
          oin_d    = pend_q ? pend_in_q : '0;
          oout_d   = pend_q ? pend_out_q : '0;
          pend_d   = 1'b0;
          slot_d   = slot_q + 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iter_cfg_q <= ITER_W'(1);
      rounds_q   <= '0;
      round_q    <= '0;
      port_q     <= '0;
      slot_q     <= '0;
      in_link_q  <= '0;
      out_link_q <= '0;
      gnt_vld_q  <= '0;
      ne_q       <= '0;
      mvld_q     <= '0;
      mrd_vld_q  <= 1'b0;
      pend_q     <= 1'b0;
      ovld_q     <= 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        gp_q[p] <= '0;
        ap_q[p] <= '0;
      end
    end else begin
      state_q    <= state_d;
      iter_cfg_q <= iter_cfg_d;
      rounds_q   <= rounds_d;
      round_q    <= round_d;
      port_q     <= port_d;
      slot_q     <= slot_d;
      in_link_q  <= in_link_d;
      out_link_q <= out_link_d;
      gnt_vld_q  <= gnt_vld_d;
      ne_q       <= ne_d;
      mvld_q     <= mvld_d;
      mrd_vld_q  <= mrd_vld_d;
      pend_q     <= pend_d;
      ovld_q     <= ovld_d;
      gp_q       <= gp_d;
      ap_q       <= ap_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    gnt_idx_q   <= gnt_idx_d;
    qsel_q      <= qsel_d;
    atime_q     <= atime_d;
    pend_time_q <= pend_time_d;
    pend_in_q   <= pend_in_d;
    pend_out_q  <= pend_out_d;
    okind_q     <= okind_d;
    optime_q    <= optime_d;
    oin_q       <= oin_d;
    oout_q      <= oout_d;
    oslot_q     <= oslot_d;
    olast_q     <= olast_d;
  end

endmodule

// ===== bench/isvs_bench_if.sv =====
// ----------------------------------------------------------------------------
// isvs_bench_pkg
// Bench types: the expected result beat kept by the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package isvs_bench_pkg;
  import isvs_pkg::*;

  // One expected result beat.
  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] packet_time;
    logic [PORT_W-1:0] match_input;
    logic [PORT_W-1:0] match_output;
    logic [TIME_W-1:0] slot_time;
    logic              last;
  } result_t;
endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives arrivals and slot commands into the iSLIP scheduler, predicts every
// result beat with a behavioral scheduler model and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import isvs_pkg::*;
  import isvs_bench_pkg::*;

  // Behavioral scheduler: virtual output queues plus round-robin pointers.
  class match_scoreboard;
    logic [TIME_W-1:0] voq [NUM_QUEUES][$];
    logic [PORT_W-1:0] grant_ptr [NUM_PORTS];
    logic [PORT_W-1:0] accept_ptr [NUM_PORTS];
    logic [TIME_W-1:0] slot_count;
    logic [ITER_W-1:0] rounds_cfg;
    result_t           pending [$];
    int                errors;

    function new();
      foreach (grant_ptr[k]) begin
        grant_ptr[k] = '0;
        accept_ptr[k] = '0;
      end
      slot_count = '0;
      rounds_cfg = 4'd1;
      errors = 0;
    endfunction

    function void add(logic [1:0] k, logic [TIME_W-1:0] t, int mi, int mo, logic l);
      result_t r;
      r.kind = k;
      r.packet_time = t;
      r.match_input = mi[PORT_W-1:0];
      r.match_output = mo[PORT_W-1:0];
      r.slot_time = slot_count;
      r.last = l;
      pending.push_back(r);
    endfunction

    // Note one accepted input beat and queue its expected results.
    function void note_input(logic op, logic [TIME_W-1:0] t, int ip, int opt);
      bit in_linked [NUM_PORTS];
      bit out_linked [NUM_PORTS];
      int granted [NUM_PORTS];
      int rounds;
      int n;
      int q;
      int c;
      if (op == OP_ARRIVAL) begin
        q = ip * NUM_PORTS + opt;
        if (voq[q].size() >= QUEUE_DEPTH) begin
          add(KIND_DROPPED, t, ip, opt, 1'b1);
        end else begin
          voq[q].push_back(t);
          add(KIND_STORED, t, ip, opt, 1'b1);
        end
        return;
      end
      rounds = (rounds_cfg > MAX_ITERATIONS) ? MAX_ITERATIONS : rounds_cfg;
      n = 0;
      foreach (in_linked[k]) begin
        in_linked[k] = 0;
        out_linked[k] = 0;
      end
      for (int it = 0; it < rounds; it++) begin
        // Grant phase.
        for (int o = 0; o < NUM_PORTS; o++) begin
          granted[o] = -1;
          if (!out_linked[o]) begin
            for (int s = 0; s < NUM_PORTS; s++) begin
              c = (grant_ptr[o] + s) % NUM_PORTS;
              if (!in_linked[c] && voq[c * NUM_PORTS + o].size() > 0) begin
                granted[o] = c;
                grant_ptr[o] = PORT_W'(c);
                break;
              end
            end
          end
        end
        // Accept phase.
        for (int i = 0; i < NUM_PORTS; i++) begin
          if (!in_linked[i]) begin
            for (int s = 0; s < NUM_PORTS; s++) begin
              c = (accept_ptr[i] + s) % NUM_PORTS;
              if (granted[c] == i) begin
                in_linked[i] = 1;
                out_linked[c] = 1;
                accept_ptr[i] = PORT_W'((c + 1) % NUM_PORTS);
                grant_ptr[c] = PORT_W'((i + 1) % NUM_PORTS);
                add(KIND_MATCH, voq[i * NUM_PORTS + c].pop_front(), i, c, 1'b0);
                n++;
                break;
              end
            end
          end
        end
      end
      if (n == 0) add(KIND_NO_MATCH, '0, 0, 0, 1'b1);
      else pending[pending.size() - 1].last = 1'b1;
      slot_count = slot_count + 1;
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); errors++;
      end
      if (got.packet_time !== exp_r.packet_time) begin
        $error("packet_time: expected %0h, got %0h", exp_r.packet_time, got.packet_time);
        errors++;
      end
      if (got.match_input !== exp_r.match_input) begin
        $error("match_input: expected %0d, got %0d", exp_r.match_input, got.match_input);
        errors++;
      end
      if (got.match_output !== exp_r.match_output) begin
        $error("match_output: expected %0d, got %0d", exp_r.match_output,
               got.match_output);
        errors++;
      end
      if (got.slot_time !== exp_r.slot_time) begin
        $error("slot_time: expected %0h, got %0h", exp_r.slot_time, got.slot_time);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ITER_W-1:0] cfg_data_i = '0;
  longint            cycles = 0;
  int                burst_left = 0;
  int                stall_mode = 0;

  isvs_in_if  in_ch ();
  isvs_out_if out_ch ();

  islip_voq_switch_scheduler_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  match_scoreboard sb = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ARRIVAL;
    in_ch.arr_stamp = '0;
    in_ch.in_port = '0;
    in_ch.out_port = '0;
    out_ch.ready = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sampling at the rising edge.
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      r.kind = out_ch.kind;
      r.packet_time = out_ch.packet_time;
      r.match_input = out_ch.match_input;
      r.match_output = out_ch.match_output;
      r.slot_time = out_ch.slot_time;
      r.last = out_ch.last;
      sb.check_result(r);
    end
  end

  // Receiver stall pattern: phases of always ready, random, and heavy stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Send one beat; valid stays high within a burst and drops for each gap.
  task automatic send_beat(logic op, logic [TIME_W-1:0] t, int ip, int opt);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.arr_stamp <= t;
    in_ch.in_port <= ip[PORT_W-1:0];
    in_ch.out_port <= opt[PORT_W-1:0];
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(op, t, ip, opt);
    @(negedge clk_i);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  // Wait until all expectations have come, plus the block's tail latency.
  task automatic drain();
    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
    end
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_rounds(logic [ITER_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.rounds_cfg = v;
  endtask

  // Random traffic phase: mostly arrivals with slot commands mixed in.
  task automatic random_phase(int count, int slot_pct);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < slot_pct) send_beat(OP_SLOT, $urandom(), 0, 0);
      else if ($urandom_range(0, 3) == 0)
        send_beat(OP_ARRIVAL, $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
      else send_beat(OP_ARRIVAL, $urandom(), $urandom_range(0, 7), $urandom_range(0, 7));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty slot, field extremes, a full queue with a drop, matches.
    send_beat(OP_SLOT, '0, 0, 0);
    send_beat(OP_ARRIVAL, '0, 0, 0);
    send_beat(OP_ARRIVAL, 32'hFFFF_FFFF, 7, 7);
    send_beat(OP_ARRIVAL, 32'hA5A5_5A5A, 7, 0);
    send_beat(OP_ARRIVAL, 32'h5A5A_A5A5, 0, 7);
    for (int k = 0; k < 17; k++) send_beat(OP_ARRIVAL, 32'h100 + k, 3, 4);
    send_beat(OP_SLOT, 32'hFFFF_FFFF, 7, 7);
    send_beat(OP_SLOT, '0, 0, 0);
    drain();

    // Zero rounds: a slot reports no match even with packets queued.
    write_rounds(4'd0);
    send_beat(OP_SLOT, '0, 0, 0);
    drain();

    // Sweep the round count through both extremes and saturation.
    write_rounds(4'd15);
    random_phase(120, 15);
    drain();
    write_rounds(4'd8);
    random_phase(100, 12);
    drain();
    write_rounds(4'd1);
    random_phase(100, 15);
    drain();
    write_rounds(4'd3);
    random_phase(100, 20);
    drain();
    write_rounds(4'd0);
    random_phase(20, 20);
    drain();
    write_rounds(4'd9);
    random_phase(60, 40);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/isvs_pkg.sv
rtl/core/isvs_in_if.sv
rtl/core/isvs_out_if.sv
rtl/core/isvs_ram.sv
rtl/core/isvs_rr_pick.sv
rtl/core/islip_voq_switch_scheduler_top.sv
bench/isvs_bench_if.sv
bench/testbench.sv
